FILE: rtl/decimal_text_field_parser_defines.svh
// Assertion macros used by the port-level checker in rtl/dtfp_checker.sv.
`ifndef DECIMAL_TEXT_FIELD_PARSER_DEFINES_SVH
`define DECIMAL_TEXT_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define DTFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtfp: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define DTFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtfp: next-cycle check failed");

`endif

FILE: rtl/dtfp_pkg.sv
`default_nettype none

package dtfp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StNoDigit  = 3'd2,
    StBadChar  = 3'd3,
    StOverflow = 3'd4
  } status_e;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharPoint = 8'h2e;

  localparam int unsigned FracW = 5;
  localparam logic [FracW-1:0] FracMax = 5'd31;
  localparam int unsigned MagW = 32;

  // Per-field flags carried from one character to the next
  typedef struct packed {
    logic             minus;
    logic             point;
    logic             digit;
    status_e          err;
    logic [FracW-1:0] frac;
    logic             at_start;
  } flags_t;

  localparam flags_t FlagsClear = '{
    minus:    1'b0,
    point:    1'b0,
    digit:    1'b0,
    err:      StOk,
    frac:     '0,
    at_start: 1'b1
  };

endpackage

`default_nettype wire

FILE: rtl/dtfp_char_if.sv
`default_nettype none

// Character channel: one character of a field per item
interface dtfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       field_empty;

  modport source (output valid, output char_code, output is_last, output field_empty,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input field_empty,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/dtfp_result_if.sv
`default_nettype none

// Result channel: one parsed field per item
interface dtfp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        negative;
  logic [31:0] magnitude;
  logic [4:0]  fraction_digits;

  modport source (output valid, output status, output negative, output magnitude,
                  output fraction_digits, input ready);
  modport sink   (input valid, input status, input negative, input magnitude,
                  input fraction_digits, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtfp_step.sv
`default_nettype none

// One parser step: folds one character into the field state and
// decides whether the field ends here.
module dtfp_step #(
  parameter int unsigned MANTISSA_BITS = 32
) (
  input  var logic [MANTISSA_BITS-1:0] acc_i,
  input  var dtfp_pkg::flags_t         flags_i,
  input  var logic                     mode_i,
  input  var logic [7:0]               char_code_i,
  input  var logic                     is_last_i,
  input  var logic                     field_empty_i,
  output logic [MANTISSA_BITS-1:0]     acc_o,
  output dtfp_pkg::flags_t             flags_o,
  output logic                         done_o,
  output dtfp_pkg::status_e            status_o,
  output logic [MANTISSA_BITS-1:0]     res_acc_o,
  output dtfp_pkg::flags_t             res_flags_o
);

  localparam int unsigned ProdW = MANTISSA_BITS + 4;

  logic             is_digit;
  logic [3:0]       digit_val;
  logic [ProdW-1:0] acc_ext;
  logic [ProdW-1:0] prod;
  logic             mant_ovf;
  logic [MANTISSA_BITS-1:0] acc_upd;
  dtfp_pkg::flags_t flags_upd;

  // acc * 10 + d as two shifts and adds; overflow shows in the top bits
  assign is_digit  = (char_code_i inside {[dtfp_pkg::CharZero:dtfp_pkg::CharNine]});
  assign digit_val = 4'(char_code_i - dtfp_pkg::CharZero);
  assign acc_ext   = ProdW'(acc_i);
  assign prod      = (acc_ext << 3) + (acc_ext << 1) + ProdW'(digit_val);
  assign mant_ovf  = |prod[ProdW-1:MANTISSA_BITS];

  // Character classification and flag update; first error wins
  always_comb begin
    acc_upd            = acc_i;
    flags_upd          = flags_i;
    flags_upd.at_start = 1'b0;
    if (flags_i.err == dtfp_pkg::StOk) begin
      if (is_digit) begin
        if (mant_ovf || (flags_i.point && flags_i.frac == dtfp_pkg::FracMax)) begin
          flags_upd.err = dtfp_pkg::StOverflow;
        end else begin
          acc_upd         = prod[MANTISSA_BITS-1:0];
          flags_upd.digit = 1'b1;
          if (flags_i.point) begin
            flags_upd.frac = flags_i.frac + 5'd1;
          end
        end
      end else if (mode_i && flags_i.at_start && char_code_i == dtfp_pkg::CharMinus) begin
        flags_upd.minus = 1'b1;
      end else if (mode_i && flags_i.at_start && char_code_i == dtfp_pkg::CharPlus) begin
        flags_upd.minus = flags_i.minus;
      end else if (mode_i && !flags_i.point && char_code_i == dtfp_pkg::CharPoint) begin
        flags_upd.point = 1'b1;
      end else begin
        flags_upd.err = dtfp_pkg::StBadChar;
      end
    end
  end

  // Field end: pick status and clear the state for the next field
  always_comb begin
    done_o      = 1'b0;
    status_o    = dtfp_pkg::StOk;
    acc_o       = acc_upd;
    flags_o     = flags_upd;
    res_acc_o   = acc_upd;
    res_flags_o = flags_upd;
    if (field_empty_i) begin
      done_o   = 1'b1;
      status_o = dtfp_pkg::StEmpty;
    end else if (is_last_i) begin
      done_o = 1'b1;
      if (flags_upd.err != dtfp_pkg::StOk) begin
        status_o = flags_upd.err;
      end else if (mode_i && !flags_upd.digit) begin
        status_o = dtfp_pkg::StNoDigit;
      end
    end
    if (done_o) begin
      acc_o   = '0;
      flags_o = dtfp_pkg::FlagsClear;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/decimal_text_field_parser.sv
// Decimal text field parser. Takes one ASCII character per item on char_i
// (is_last marks the final character, field_empty stands for a field with no
// characters) and returns one result per field on result_o: status, sign,
// the digits as one unsigned integer, and the count of digits after the point,
// so the value is magnitude / 10^fraction_digits. decimal_mode = 0 accepts
// digits only; 1 also accepts one leading sign and one point and requires a
// digit. On any failure the payload fields are zero. Throughput is one
// character per cycle while the result side is not stalled; a result is offered once
// its last character is in the input register and the step has moved into the
// result register. The rate is set by the accumulator loop, one multiply-by-ten
// add per cycle. An output register decouples the two sides; while a result
// waits, the input register holds its character, whether or not that
// character ends a field.
`default_nettype none

module decimal_text_field_parser #(
  parameter int unsigned MANTISSA_BITS = 32
) (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          decimal_mode_we_i,
  input  var logic          decimal_mode_i,
  dtfp_char_if.sink         char_i,
  dtfp_result_if.source     result_o
);

  logic mode_q;

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       empty_q;

  logic [MANTISSA_BITS-1:0] acc_q, acc_d;
  dtfp_pkg::flags_t         flags_q, flags_d;

  logic                     done;
  dtfp_pkg::status_e        status;
  logic [MANTISSA_BITS-1:0] res_acc;
  dtfp_pkg::flags_t         res_flags;
  logic [MANTISSA_BITS+31:0] res_acc_ext;

  logic        out_vld_q;
  logic [2:0]  status_q;
  logic        negative_q;
  logic [31:0] magnitude_q;
  logic [4:0]  frac_q;

  logic accept;
  logic advance;

  // Handshake: the input stage moves when the result register can take a result
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign char_i.ready = !in_vld_q || advance;
  assign accept       = char_i.valid && char_i.ready;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (decimal_mode_we_i) begin
      mode_q <= decimal_mode_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q  <= char_i.char_code;
      last_q  <= char_i.is_last;
      empty_q <= char_i.field_empty;
    end
  end

  dtfp_step #(
    .MANTISSA_BITS(MANTISSA_BITS)
  ) u_step (
    .acc_i        (acc_q),
    .flags_i      (flags_q),
    .mode_i       (mode_q),
    .char_code_i  (char_q),
    .is_last_i    (last_q),
    .field_empty_i(empty_q),
    .acc_o        (acc_d),
    .flags_o      (flags_d),
    .done_o       (done),
    .status_o     (status),
    .res_acc_o    (res_acc),
    .res_flags_o  (res_flags)
  );

  // Field state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      flags_q <= dtfp_pkg::FlagsClear;
    end else if (advance) begin
      acc_q   <= acc_d;
      flags_q <= flags_d;
    end
  end

  // Result register
  assign res_acc_ext = {32'd0, res_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && done) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && done) begin
      status_q <= status;
      if (status == dtfp_pkg::StOk) begin
        negative_q  <= res_flags.minus;
        magnitude_q <= res_acc_ext[31:0];
        frac_q      <= res_flags.frac;
      end else begin
        negative_q  <= 1'b0;
        magnitude_q <= '0;
        frac_q      <= '0;
      end
    end
  end

  assign result_o.valid           = out_vld_q;
  assign result_o.status          = status_q;
  assign result_o.negative        = negative_q;
  assign result_o.magnitude       = magnitude_q;
  assign result_o.fraction_digits = frac_q;

endmodule

`default_nettype wire

FILE: rtl/dtfp_checker.sv
`default_nettype none

`include "decimal_text_field_parser_defines.svh"

// Port-level checks on the parser's result channel
module dtfp_checker (
  input var logic        clk_i,
  input var logic        rst_ni,
  input var logic        cfg_we_i,
  input var logic        cfg_mode_i,
  input var logic        out_valid_i,
  input var logic        out_ready_i,
  input var logic [2:0]  status_i,
  input var logic        negative_i,
  input var logic [31:0] magnitude_i,
  input var logic [4:0]  frac_i
);

  logic        mode_q;
  logic        out_ok;
  logic        out_fail;
  logic        out_stall;
  logic [40:0] out_payload;
  logic        payload_zero;
  logic        plain_ok;

  // Shadow of the mode register, from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_mode_i;
    end
  end

  assign out_ok       = out_valid_i && (status_i == dtfp_pkg::StOk);
  assign out_fail     = out_valid_i && (status_i != dtfp_pkg::StOk);
  assign out_stall    = out_valid_i && !out_ready_i;
  assign out_payload  = {status_i, negative_i, magnitude_i, frac_i};
  assign payload_zero = !negative_i && magnitude_i == 32'd0 && frac_i == 5'd0;
  assign plain_ok     = !negative_i && frac_i == 5'd0 && status_i != dtfp_pkg::StNoDigit;

  // A stalled result stays offered and unchanged
  `DTFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `DTFP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_payload))

  // A failed field carries a zero payload
  `DTFP_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_fail, payload_zero)

  // Unsigned mode: no sign, no fraction, never the no-digit status
  `DTFP_ASSERT_NOW(a_unsigned_plain, clk_i, rst_ni, out_valid_i && !mode_q, plain_ok)

  // Fraction digits only show up in decimal mode
  `DTFP_ASSERT_NOW(a_frac_mode, clk_i, rst_ni, out_ok && frac_i != 5'd0, mode_q)

endmodule

bind decimal_text_field_parser dtfp_checker u_dtfp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_we_i   (decimal_mode_we_i),
  .cfg_mode_i (decimal_mode_i),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .status_i   (result_o.status),
  .negative_i (result_o.negative),
  .magnitude_i(result_o.magnitude),
  .frac_i     (result_o.fraction_digits)
);

`default_nettype wire

FILE: sim/decimal_text_field_parser_checker.sv
// Watches both channels and the mode port, predicts one result per field end
// and compares every accepted result against the oldest prediction.
module decimal_text_field_parser_checker
  import dtfp_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        mode_we_i,
  input  var logic        mode_i,
  dtfp_char_if            char_i,
  dtfp_result_if          result_i,
  output int unsigned     mismatch_count_o,
  output int unsigned     pending_o
);

  typedef struct {
    status_e          status;
    logic             negative;
    logic [MagW-1:0]  magnitude;
    logic [FracW-1:0] fraction_digits;
  } field_result_t;

  field_result_t expected_fields[$];
  field_result_t want;

  // Shadow of the mode register and of the per-field parse state
  logic             decimal_mode_q;
  logic [MagW-1:0]  mantissa_q;
  logic             minus_q;
  logic             point_q;
  logic             digit_q;
  logic             start_q;
  status_e          err_q;
  logic [FracW-1:0] frac_q;

  function automatic void clear_field();
    mantissa_q = '0;
    minus_q    = 1'b0;
    point_q    = 1'b0;
    digit_q    = 1'b0;
    start_q    = 1'b1;
    err_q      = StOk;
    frac_q     = '0;
  endfunction

  // Advance the field state by one character; queue a result at field end
  function automatic void parse_char(input logic [7:0] c, input logic last,
                                     input logic empty);
    logic            first;
    logic [MagW+3:0] wide;
    status_e         st;
    field_result_t   r;
    if (empty) begin
      st = StEmpty;
    end else begin
      first   = start_q;
      start_q = 1'b0;
      // first error wins: later characters leave the state alone
      if (err_q == StOk) begin
        if (c >= CharZero && c <= CharNine) begin
          wide = {4'b0, mantissa_q} * 10 + (c - CharZero);
          if (wide > {4'b0, {MagW{1'b1}}}) begin
            err_q = StOverflow;
          end else if (point_q && frac_q >= FracMax) begin
            err_q = StOverflow;
          end else begin
            if (point_q) frac_q++;
            mantissa_q = wide[MagW-1:0];
            digit_q    = 1'b1;
          end
        end else if (decimal_mode_q && first && c == CharMinus) begin
          minus_q = 1'b1;
        end else if (decimal_mode_q && first && c == CharPlus) begin
          // leading plus changes nothing
        end else if (decimal_mode_q && c == CharPoint && !point_q) begin
          point_q = 1'b1;
        end else begin
          err_q = StBadChar;
        end
      end
      if (!last) return;
      if (err_q != StOk) st = err_q;
      else if (decimal_mode_q && !digit_q) st = StNoDigit;
      else st = StOk;
    end
    r.status          = st;
    r.negative        = (st == StOk) ? minus_q : 1'b0;
    r.magnitude       = (st == StOk) ? mantissa_q : '0;
    r.fraction_digits = (st == StOk) ? frac_q : '0;
    expected_fields.push_back(r);
    clear_field();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_fields.delete();
      decimal_mode_q   = 1'b0;
      mismatch_count_o = 0;
      pending_o       <= 0;
      clear_field();
    end else begin
      // compare the outgoing item before taking in a new character
      if (result_i.valid && result_i.ready) begin
        if (expected_fields.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result with no field pending: status=%0d neg=%0d mag=%0d frac=%0d",
                   $time, result_i.status, result_i.negative, result_i.magnitude,
                   result_i.fraction_digits);
        end else begin
          want = expected_fields.pop_front();
          if (result_i.status !== want.status || result_i.negative !== want.negative ||
              result_i.magnitude !== want.magnitude ||
              result_i.fraction_digits !== want.fraction_digits) begin
            mismatch_count_o++;
            $display("%0t: result mismatch: expected status=%0d neg=%0d mag=%0d frac=%0d",
                     $time, want.status, want.negative, want.magnitude,
                     want.fraction_digits);
            $display("%0t:                  actual   status=%0d neg=%0d mag=%0d frac=%0d",
                     $time, result_i.status, result_i.negative, result_i.magnitude,
                     result_i.fraction_digits);
          end
        end
      end
      if (char_i.valid && char_i.ready) begin
        parse_char(char_i.char_code, char_i.is_last, char_i.field_empty);
      end
      if (mode_we_i) decimal_mode_q = mode_i;
      pending_o <= expected_fields.size();
    end
  end

endmodule

FILE: sim/decimal_text_field_parser_tb.sv
// Stimulus and verdict; all prediction lives in the checker beside the block.
module decimal_text_field_parser_tb;
  import dtfp_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned ItemTarget = 1350;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleCycles = 4;

  typedef logic [7:0] text_t[$];

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        mode_we  = 1'b0;
  logic        mode_val = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned chars_sent = 0;
  int unsigned cycles     = 0;
  logic        quiet        = 1'b0;
  logic        hold_pending = 1'b0;

  dtfp_char_if   chars ();
  dtfp_result_if results ();

  decimal_text_field_parser dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .decimal_mode_we_i (mode_we),
    .decimal_mode_i    (mode_val),
    .char_i            (chars),
    .result_o          (results)
  );

  decimal_text_field_parser_checker field_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .mode_we_i        (mode_we),
    .mode_i           (mode_val),
    .char_i           (chars),
    .result_i         (results),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls plus an occasional long hold-off
  initial begin
    results.ready = 1'b0;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        results.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      results.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last, input logic empty);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid       <= 1'b1;
    chars.char_code   <= c;
    chars.is_last     <= last;
    chars.field_empty <= empty;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_field(input text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1, 1'b0);
  endtask

  task automatic send_str(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_field(t);
  endtask

  task automatic write_mode(input logic v);
    mode_we  <= 1'b1;
    mode_val <= v;
    @(posedge clk);
    mode_we  <= 1'b0;
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe settle
  task automatic drain();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  // One random field for the given mode
  function automatic text_t build_field(input logic dec);
    text_t       t;
    int unsigned kind, n, p;
    logic [7:0]  sym[3];
    int unsigned top_digits[8] = '{4, 2, 9, 4, 9, 6, 7, 2};
    sym  = '{CharMinus, CharPlus, CharPoint};
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // plain number, the upper part of this range with one character spoiled
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 11) : $urandom_range(1, 9);
      for (int i = 0; i < n; i++) t.push_back(CharZero + 8'($urandom_range(0, 9)));
      if (dec && $urandom_range(0, 1)) t.insert($urandom_range(0, n), CharPoint);
      if (dec && $urandom_range(0, 2) == 0) begin
        t.push_front($urandom_range(0, 1) ? CharMinus : CharPlus);
      end
      if (kind >= 45) begin
        p = $urandom_range(0, t.size() - 1);
        t[p] = $urandom_range(0, 1) ? sym[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
      end
    end else if (kind < 70) begin
      // straddles the largest mantissa
      if (dec && $urandom_range(0, 1)) t.push_back(CharMinus);
      foreach (top_digits[i]) t.push_back(CharZero + 8'(top_digits[i]));
      t.push_back(CharZero + 8'($urandom_range(8, 9)));
      t.push_back(CharZero + 8'($urandom_range(0, 9)));
    end else if (kind < 74) begin
      // long run of zeros, after a point in decimal mode, around the fraction digit limit
      if ($urandom_range(0, 1)) t.push_back(CharZero);
      if (dec) t.push_back(CharPoint);
      n = $urandom_range(29, 33);
      for (int i = 0; i < n; i++) t.push_back(CharZero);
      if ($urandom_range(0, 1)) t.push_back(CharZero + 8'($urandom_range(0, 9)));
    end else if (kind < 88) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      // signs and points, maybe a digit after
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) t.push_back(sym[$urandom_range(0, 2)]);
      if ($urandom_range(0, 1)) t.push_back(CharZero + 8'($urandom_range(0, 9)));
    end
    return t;
  endfunction

  initial begin
    int unsigned phase, quota, r;
    text_t       t;
    chars.valid       = 1'b0;
    chars.char_code   = '0;
    chars.is_last     = 1'b0;
    chars.field_empty = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unsigned mode
    write_mode(1'b0);
    send_str("0");
    send_char(8'hff, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    send_char(CharZero + 8'd7, 1'b0, 1'b0);
    send_char(8'hff, 1'b1, 1'b1);
    send_str("+5");
    send_str("a5");
    drain();

    // Directed: decimal mode
    write_mode(1'b1);
    send_str("-");
    send_str(".");
    send_str("-1.5");
    send_str("1..9");
    send_str("5-");
    send_str("+.5");
    drain();

    // Random phases, each under its own mode setting
    phase = 0;
    while (chars_sent < ItemTarget) begin
      write_mode(phase < 2 ? phase[0] : ($urandom_range(0, 3) != 0));
      quiet = (phase % 4 == 3);
      if (phase == 1 || phase == 5) hold_pending = 1'b1;
      quota = chars_sent + $urandom_range(80, 200);
      if (quota > ItemTarget) quota = ItemTarget;
      while (chars_sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
          t = build_field(mode_val);
          if (r < 12) begin
            // field cut short by an empty mark
            foreach (t[i]) send_char(t[i], 1'b0, 1'b0);
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
          end else begin
            send_field(t);
          end
        end
      end
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
